// ===== hw/rtl/nls_pkg.sv =====
// Shared types and codes for the numeric literal scanner.
// Used by numeric_literal_scanner; depends on nothing.
package nls_pkg;

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_FLOAT = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_t;

  typedef struct packed {
    logic       first;
    logic [7:0] ch;
    logic       end_of_source;
  } src_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  radix;
    logic [63:0] value;
    logic        overflow;
    logic        is_unsigned;
    logic        is_long;
    logic        is_long_long;
    logic        is_float_suffix;
    logic [15:0] length;
  } tok_word_t;

endpackage

// ===== hw/rtl/numeric_literal_scanner.sv =====
// Numeric literal scanner: one source byte per cycle in while src_ready is high, one token word per literal out.
// Depends on nls_pkg (word types, kind and radix codes).
//
// Takes one source byte every cycle while src_ready is high and recognizes a C/C++ numeric
// literal (decimal, hex, octal, binary, fractions, exponents, u/l/ll and f/l suffixes). Each
// byte goes through one register stage: the phase step and the value shift-add sit between
// the scan state registers, so the sustained rate is one byte per cycle while src_ready is
// high. The token word is written into the output buffer by the byte that ends the literal
// (that byte itself is dropped, not counted). A two-word output buffer lets src_ready stay
// high while a token waits for tok_ready; src_ready drops only when both entries are full.
module numeric_literal_scanner (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  nls_pkg::src_word_t src_word,
  output logic               tok_valid,
  input  logic               tok_ready,
  output nls_pkg::tok_word_t tok_word
);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_ZERO       = 4'd1,
    PH_DEC_INT    = 4'd2,
    PH_OCT_INT    = 4'd3,
    PH_HEX_FIRST  = 4'd4,
    PH_HEX_INT    = 4'd5,
    PH_BIN_FIRST  = 4'd6,
    PH_BIN_INT    = 4'd7,
    PH_DEC_FRAC   = 4'd8,
    PH_DOT_FRAC   = 4'd9,
    PH_HEX_FRAC   = 4'd10,
    PH_EXP_SIGN   = 4'd11,
    PH_EXP_DIGITS = 4'd12,
    PH_ISUFFIX    = 4'd13,
    PH_DONE       = 4'd14
  } phase_t;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_SEP  = 8'h27;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MIN  = 8'h2D;
  localparam logic [7:0] CH_LC_X = 8'h78;
  localparam logic [7:0] CH_UC_X = 8'h58;
  localparam logic [7:0] CH_LC_B = 8'h62;
  localparam logic [7:0] CH_UC_B = 8'h42;
  localparam logic [7:0] CH_LC_E = 8'h65;
  localparam logic [7:0] CH_UC_E = 8'h45;
  localparam logic [7:0] CH_LC_P = 8'h70;
  localparam logic [7:0] CH_UC_P = 8'h50;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_UC_F = 8'h46;
  localparam logic [7:0] CH_LC_L = 8'h6C;
  localparam logic [7:0] CH_UC_L = 8'h4C;
  localparam logic [7:0] CH_LC_U = 8'h75;
  localparam logic [7:0] CH_UC_U = 8'h55;

  localparam int SF_U  = 0;
  localparam int SF_L  = 1;
  localparam int SF_LL = 2;
  localparam int SF_F  = 3;

  localparam logic [1:0] ELL_NONE  = 2'd0;
  localparam logic [1:0] ELL_LOWER = 2'd1;
  localparam logic [1:0] ELL_UPPER = 2'd2;

  // scan state
  phase_t      scan_phase, scan_phase_next;
  logic [1:0]  radix_seen, radix_seen_next;
  logic        float_seen, float_seen_next;
  logic [63:0] accumulated_value, accumulated_value_next;
  logic        overflow_seen, overflow_seen_next;
  logic [3:0]  suffix_flags, suffix_flags_next;
  logic [1:0]  suffix_steps, suffix_steps_next;
  logic [1:0]  pending_ell, pending_ell_next;
  logic [15:0] char_count, char_count_next;

  // output buffer
  logic               out_valid, skid_valid;
  nls_pkg::tok_word_t out_data, skid_data;

  logic               src_fire, tok_fire;
  logic               emit;
  logic [1:0]         emit_kind;
  nls_pkg::tok_word_t result;

  logic [7:0]  c;
  logic        c_dec, c_oct, c_hex, c_bin;
  logic [3:0]  digit;
  logic [67:0] mac;
  logic        mac_ovf;

  assign src_ready = !skid_valid;
  assign src_fire  = src_valid && src_ready;
  assign tok_fire  = out_valid && tok_ready;
  assign tok_valid = out_valid;
  assign tok_word  = out_data;

  assign c     = src_word.ch;
  assign c_dec = (c inside {[8'h30:8'h39]});
  assign c_oct = (c inside {[8'h30:8'h37]});
  assign c_hex = c_dec || (c inside {[8'h61:8'h66], [8'h41:8'h46]});
  assign c_bin = (c == CH_ZERO) || (c == CH_ONE);
  assign digit = c_dec ? c[3:0] : c[3:0] + 4'd9;

  // value * base + digit; anything above bit 63 means overflow
  always_comb begin
    case (scan_phase)
      PH_HEX_FIRST, PH_HEX_INT: mac = {accumulated_value, 4'b0};
      PH_BIN_FIRST, PH_BIN_INT: mac = {3'b0, accumulated_value, 1'b0};
      PH_ZERO, PH_OCT_INT:      mac = {1'b0, accumulated_value, 3'b0};
      default:                  mac = {1'b0, accumulated_value, 3'b0}
                                    + {3'b0, accumulated_value, 1'b0};
    endcase
    mac     = mac + {64'b0, digit};
    mac_ovf = |mac[67:64];
  end

  always_comb begin
    logic go_int, go_flt, go_fin, do_take, do_accum, ell_done;
    logic [7:0] want;

    scan_phase_next        = scan_phase;
    radix_seen_next        = radix_seen;
    float_seen_next        = float_seen;
    accumulated_value_next = accumulated_value;
    overflow_seen_next     = overflow_seen;
    suffix_flags_next      = suffix_flags;
    suffix_steps_next      = suffix_steps;
    pending_ell_next       = pending_ell;
    char_count_next        = char_count;
    emit      = 1'b0;
    emit_kind = nls_pkg::KIND_INT;
    go_int    = 1'b0;
    go_flt    = 1'b0;
    go_fin    = 1'b0;
    do_take   = 1'b0;
    do_accum  = 1'b0;
    ell_done  = 1'b0;
    want      = CH_LC_L;

    if (src_word.end_of_source) begin
      if (scan_phase == PH_IDLE) begin
      end else if (scan_phase == PH_HEX_FIRST || scan_phase == PH_BIN_FIRST) begin
        emit      = 1'b1;
        emit_kind = nls_pkg::KIND_ERROR;
      end else begin
        if (pending_ell != ELL_NONE) begin
          pending_ell_next        = ELL_NONE;
          suffix_flags_next[SF_L] = 1'b1;
        end
        go_fin = 1'b1;
      end
    end else if (src_word.first) begin
      radix_seen_next        = nls_pkg::RADIX_DEC;
      float_seen_next        = 1'b0;
      accumulated_value_next = '0;
      overflow_seen_next     = 1'b0;
      suffix_flags_next      = '0;
      suffix_steps_next      = '0;
      pending_ell_next       = ELL_NONE;
      if (c == CH_ZERO) begin
        char_count_next = 16'd1;
        scan_phase_next = PH_ZERO;
      end else if (c_dec) begin
        accumulated_value_next = {60'b0, c[3:0]};
        char_count_next        = 16'd1;
        scan_phase_next        = PH_DEC_INT;
      end else if (c == CH_DOT) begin
        float_seen_next = 1'b1;
        char_count_next = 16'd1;
        scan_phase_next = PH_DOT_FRAC;
      end else begin
        char_count_next = '0;
        emit            = 1'b1;
        emit_kind       = nls_pkg::KIND_ERROR;
      end
    end else if (scan_phase != PH_IDLE) begin
      case (scan_phase)
        PH_ZERO: begin
          if (c == CH_LC_X || c == CH_UC_X) begin
            do_take         = 1'b1;
            radix_seen_next = nls_pkg::RADIX_HEX;
            scan_phase_next = PH_HEX_FIRST;
          end else if (c == CH_LC_B || c == CH_UC_B) begin
            do_take         = 1'b1;
            radix_seen_next = nls_pkg::RADIX_BIN;
            scan_phase_next = PH_BIN_FIRST;
          end else if (c_oct || c == CH_SEP) begin
            radix_seen_next = nls_pkg::RADIX_OCT;
            do_accum        = c_oct;
            do_take         = 1'b1;
            scan_phase_next = PH_OCT_INT;
          end else if (c == CH_DOT) begin
            float_seen_next = 1'b1;
            do_take         = 1'b1;
            scan_phase_next = PH_DEC_FRAC;
          end else if (c == CH_LC_E || c == CH_UC_E) begin
            float_seen_next = 1'b1;
            do_take         = 1'b1;
            scan_phase_next = PH_EXP_SIGN;
          end else begin
            go_int = 1'b1;
          end
        end
        PH_DEC_INT: begin
          if (c_dec) begin
            do_accum = 1'b1;
            do_take  = 1'b1;
          end else if (c == CH_SEP) begin
            do_take = 1'b1;
          end else if (c == CH_DOT) begin
            float_seen_next = 1'b1;
            do_take         = 1'b1;
            scan_phase_next = PH_DEC_FRAC;
          end else if (c == CH_LC_E || c == CH_UC_E) begin
            float_seen_next = 1'b1;
            do_take         = 1'b1;
            scan_phase_next = PH_EXP_SIGN;
          end else begin
            go_int = 1'b1;
          end
        end
        PH_OCT_INT: begin
          if (c_oct) begin
            do_accum = 1'b1;
            do_take  = 1'b1;
          end else if (c == CH_SEP) begin
            do_take = 1'b1;
          end else begin
            go_int = 1'b1;
          end
        end
        PH_HEX_FIRST: begin
          if (c_hex) begin
            do_accum        = 1'b1;
            do_take         = 1'b1;
            scan_phase_next = PH_HEX_INT;
          end else begin
            emit      = 1'b1;
            emit_kind = nls_pkg::KIND_ERROR;
          end
        end
        PH_HEX_INT: begin
          if (c_hex) begin
            do_accum = 1'b1;
            do_take  = 1'b1;
          end else if (c == CH_SEP) begin
            do_take = 1'b1;
          end else if (c == CH_DOT) begin
            float_seen_next = 1'b1;
            do_take         = 1'b1;
            scan_phase_next = PH_HEX_FRAC;
          end else if (c == CH_LC_P || c == CH_UC_P) begin
            float_seen_next = 1'b1;
            do_take         = 1'b1;
            scan_phase_next = PH_EXP_SIGN;
          end else begin
            go_int = 1'b1;
          end
        end
        PH_BIN_FIRST: begin
          if (c_bin) begin
            do_accum        = 1'b1;
            do_take         = 1'b1;
            scan_phase_next = PH_BIN_INT;
          end else begin
            emit      = 1'b1;
            emit_kind = nls_pkg::KIND_ERROR;
          end
        end
        PH_BIN_INT: begin
          if (c_bin) begin
            do_accum = 1'b1;
            do_take  = 1'b1;
          end else if (c == CH_SEP) begin
            do_take = 1'b1;
          end else begin
            go_int = 1'b1;
          end
        end
        PH_DEC_FRAC: begin
          if (c_dec || c == CH_SEP) begin
            do_take = 1'b1;
          end else if (c == CH_LC_E || c == CH_UC_E) begin
            do_take         = 1'b1;
            scan_phase_next = PH_EXP_SIGN;
          end else begin
            go_flt = 1'b1;
          end
        end
        PH_DOT_FRAC: begin
          if (c_dec) begin
            do_take = 1'b1;
          end else if (c == CH_LC_E || c == CH_UC_E) begin
            do_take         = 1'b1;
            scan_phase_next = PH_EXP_SIGN;
          end else begin
            go_flt = 1'b1;
          end
        end
        PH_HEX_FRAC: begin
          if (c_hex || c == CH_SEP) begin
            do_take = 1'b1;
          end else if (c == CH_LC_P || c == CH_UC_P) begin
            do_take         = 1'b1;
            scan_phase_next = PH_EXP_SIGN;
          end else begin
            go_flt = 1'b1;
          end
        end
        PH_EXP_SIGN: begin
          if (c == CH_PLUS || c == CH_MIN || c_dec) begin
            do_take         = 1'b1;
            scan_phase_next = PH_EXP_DIGITS;
          end else begin
            go_flt = 1'b1;
          end
        end
        PH_EXP_DIGITS: begin
          if (c_dec) begin
            do_take = 1'b1;
          end else begin
            go_flt = 1'b1;
          end
        end
        PH_ISUFFIX: go_int = 1'b1;
        PH_DONE:    go_fin = 1'b1;
        default: begin
          scan_phase_next = PH_IDLE;
          char_count_next = '0;
        end
      endcase

      // float suffix
      if (go_flt) begin
        if (c == CH_LC_F || c == CH_UC_F) begin
          suffix_flags_next[SF_F] = 1'b1;
          do_take                 = 1'b1;
          scan_phase_next         = PH_DONE;
        end else if (c == CH_LC_L || c == CH_UC_L) begin
          suffix_flags_next[SF_L] = 1'b1;
          do_take                 = 1'b1;
          scan_phase_next         = PH_DONE;
        end else begin
          go_fin = 1'b1;
        end
      end

      // integer suffix steps
      if (go_int) begin
        scan_phase_next = PH_ISUFFIX;
        if (pending_ell != ELL_NONE) begin
          want              = (pending_ell == ELL_LOWER) ? CH_LC_L : CH_UC_L;
          pending_ell_next  = ELL_NONE;
          suffix_steps_next = suffix_steps_next + 2'd1;
          if (c == want) begin
            suffix_flags_next[SF_LL] = 1'b1;
            do_take                  = 1'b1;
            ell_done                 = 1'b1;
          end else begin
            suffix_flags_next[SF_L] = 1'b1;
          end
        end
        if (!ell_done) begin
          if (suffix_steps_next == 2'd3) begin
            go_fin = 1'b1;
          end else if (c == CH_LC_U || c == CH_UC_U) begin
            if (suffix_flags_next[SF_U]) begin
              go_fin = 1'b1;
            end else begin
              suffix_flags_next[SF_U] = 1'b1;
              suffix_steps_next       = suffix_steps_next + 2'd1;
              do_take                 = 1'b1;
            end
          end else if (c == CH_LC_L || c == CH_UC_L) begin
            if (suffix_flags_next[SF_L] || suffix_flags_next[SF_LL]) begin
              go_fin = 1'b1;
            end else begin
              pending_ell_next = (c == CH_LC_L) ? ELL_LOWER : ELL_UPPER;
              do_take          = 1'b1;
            end
          end else begin
            go_fin = 1'b1;
          end
        end
      end

      if (do_accum && !overflow_seen) begin
        if (mac_ovf) begin
          overflow_seen_next     = 1'b1;
          accumulated_value_next = '1;
        end else begin
          accumulated_value_next = mac[63:0];
        end
      end

      if (do_take && char_count != 16'hFFFF) begin
        char_count_next = char_count + 16'd1;
      end
    end

    if (go_fin) begin
      emit      = 1'b1;
      emit_kind = float_seen_next ? nls_pkg::KIND_FLOAT : nls_pkg::KIND_INT;
    end

    result.kind            = emit_kind;
    result.radix           = radix_seen_next;
    result.value           = (emit_kind == nls_pkg::KIND_INT) ? accumulated_value_next : '0;
    result.overflow        = (emit_kind == nls_pkg::KIND_INT) && overflow_seen_next;
    result.is_unsigned     = (emit_kind == nls_pkg::KIND_INT) && suffix_flags_next[SF_U];
    result.is_long         = (emit_kind != nls_pkg::KIND_ERROR) && suffix_flags_next[SF_L];
    result.is_long_long    = (emit_kind == nls_pkg::KIND_INT) && suffix_flags_next[SF_LL];
    result.is_float_suffix = (emit_kind == nls_pkg::KIND_FLOAT) && suffix_flags_next[SF_F];
    result.length          = char_count_next;

    if (emit) begin
      scan_phase_next        = PH_IDLE;
      radix_seen_next        = nls_pkg::RADIX_DEC;
      float_seen_next        = 1'b0;
      accumulated_value_next = '0;
      overflow_seen_next     = 1'b0;
      suffix_flags_next      = '0;
      suffix_steps_next      = '0;
      pending_ell_next       = ELL_NONE;
      char_count_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase        <= PH_IDLE;
      radix_seen        <= nls_pkg::RADIX_DEC;
      float_seen        <= 1'b0;
      accumulated_value <= '0;
      overflow_seen     <= 1'b0;
      suffix_flags      <= '0;
      suffix_steps      <= '0;
      pending_ell       <= ELL_NONE;
      char_count        <= '0;
    end else if (src_fire) begin
      scan_phase        <= scan_phase_next;
      radix_seen        <= radix_seen_next;
      float_seen        <= float_seen_next;
      accumulated_value <= accumulated_value_next;
      overflow_seen     <= overflow_seen_next;
      suffix_flags      <= suffix_flags_next;
      suffix_steps      <= suffix_steps_next;
      pending_ell       <= pending_ell_next;
      char_count        <= char_count_next;
    end
  end

  // two-entry output buffer: out_data is the head, skid_data the second word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (tok_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (src_fire && emit) begin
      if (!out_valid || tok_fire) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (tok_fire) begin
      out_valid <= 1'b0;
    end
  end

  a_skid_implies_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("second word held without a head word");

  a_skid_drains_to_head: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && tok_ready) |=> (out_valid && !skid_valid))
    else $error("second word lost on drain");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    (scan_phase == PH_IDLE) |-> (char_count == 16'd0 && pending_ell == ELL_NONE))
    else $error("idle scanner holds literal state");

  a_overflow_saturates: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (accumulated_value == 64'hFFFF_FFFF_FFFF_FFFF))
    else $error("overflowed value not saturated");

  a_non_int_value_zero: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_word.kind != nls_pkg::KIND_INT) |->
      (tok_word.value == 64'd0 && !tok_word.overflow))
    else $error("non-integer token carries a value");

endmodule
